// ----- rtl/core/vca_group_gain_core_assert.svh -----
// assertion macros shared by the vca group gain core modules
`ifndef VCA_GROUP_GAIN_CORE_ASSERT_SVH
`define VCA_GROUP_GAIN_CORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define VGG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vgg same-cycle check failed");

// condition must hold in the cycle after the trigger
`define VGG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vgg next-cycle check failed");

`endif

// ----- rtl/core/vgg_pkg.sv -----
// shared constants, types and the gain table builder for the vca group gain core
`timescale 1ns / 1ps

package vgg_pkg;

	localparam int GROUP_COUNT_DEF   = 16;
	localparam int CHANNEL_COUNT_DEF = 64;

	// payload widths
	localparam int ACTION_W  = 3;
	localparam int GROUP_W   = 4;
	localparam int CHANNEL_W = 6;
	localparam int FADER_W   = 12;
	localparam int NEWG_W    = 4;
	localparam int GAIN_W    = 24;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_CREATE    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ASSIGN    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_UNASSIGN  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SET_FADER = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd4;

	// status codes
	localparam logic STAT_DONE     = 1'b0;
	localparam logic STAT_REJECTED = 1'b1;

	// clamp range of the fader sum, in 1/16 dB
	localparam int SUM_MIN = -2304;
	localparam int SUM_MAX = 384;

	localparam int ROM_DEPTH = SUM_MAX - SUM_MIN + 1;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h10_0000;

	// fixed point used to build the table
	localparam int DB16_PER_DECADE = 320;
	localparam int DECADES_BELOW   = 8;
	localparam int SERIES_TERMS    = 40;
	localparam logic [63:0] Q_ONE      = 64'h1000_0000_0000_0000;
	localparam logic [63:0] ROUND_HALF = 64'h0000_0080_0000_0000;

	typedef logic [GAIN_W-1:0] gain_rom_t [ROM_DEPTH];

	// controller to datapath commands
	typedef struct packed {
		logic ready;
		logic load;
		logic start;
		logic exec;
		logic walk;
		logic clamp;
		logic rom;
		logic push;
	} vgg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_valid;
		logic is_query;
		logic none_in_use;
		logic walk_last;
		logic out_busy;
	} vgg_stat_t;

	// floor quotient by restoring long division, used while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ln(10) in q4.60 from 6*atanh(1/3) + 2*atanh(1/9)
	function automatic logic [63:0] ln10_q60();
		logic [63:0] pw;
		logic [63:0] acc;
		logic [63:0] total;
		logic [63:0] p;
		total = '0;
		for (int i = 0; i < 2; i++) begin
			p = (i == 0) ? 64'd3 : 64'd9;
			pw = udiv64(Q_ONE, p);
			acc = '0;
			for (int k = 0; k < SERIES_TERMS; k++) begin
				acc = acc + udiv64(pw, 64'(2 * k + 1));
				pw = udiv64(pw, p * p);
			end
			total = total + acc * ((i == 0) ? 64'd6 : 64'd2);
		end
		return total;
	endfunction

	// gain table indexed by clamped sum minus SUM_MIN, unsigned q4.20
	function automatic gain_rom_t build_gain_rom();
		gain_rom_t rom;
		logic [63:0] ln10;
		logic [63:0] ln10_q;
		logic [63:0] ln10_r;
		logic [63:0] mm;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] v;
		logic [63:0] x;
		logic [127:0] prod;
		int idx;
		ln10 = ln10_q60();
		ln10_q = udiv64(ln10, 64'(DB16_PER_DECADE));
		ln10_r = ln10 - ln10_q * 64'(DB16_PER_DECADE);
		for (int m = 0; m < DB16_PER_DECADE; m++) begin
			mm = 64'(m);
			y = ln10_q * mm + udiv64(ln10_r * mm, 64'(DB16_PER_DECADE));
			term = Q_ONE;
			v = Q_ONE;
			for (int n = 1; n < SERIES_TERMS; n++) begin
				prod = 128'(term) * 128'(y);
				term = udiv64(prod[123:60], 64'(n));
				v = v + term;
			end
			for (int j = 0; j < 10; j++) begin
				idx = DB16_PER_DECADE * j + m - (DB16_PER_DECADE * DECADES_BELOW + SUM_MIN);
				if (idx >= 0 && idx < ROM_DEPTH) begin
					x = v;
					if (j > DECADES_BELOW) begin
						for (int r = 0; r < j - DECADES_BELOW; r++)
							x = x * 64'd10;
					end else begin
						for (int r = 0; r < DECADES_BELOW - j; r++)
							x = udiv64(x, 64'd10);
					end
					rom[idx] = GAIN_W'((x + ROUND_HALF) >> 40);
				end
			end
		end
		return rom;
	endfunction

endpackage

// ----- rtl/core/vgg_in_if.sv -----
// request channel: one action per transfer
`timescale 1ns / 1ps

interface vgg_in_if;
	logic                                valid;
	logic                                ready;
	logic [vgg_pkg::ACTION_W-1:0]        action;
	logic [vgg_pkg::GROUP_W-1:0]         group_index;
	logic [vgg_pkg::CHANNEL_W-1:0]       channel_index;
	logic signed [vgg_pkg::FADER_W-1:0]  fader_level;

	modport source (output valid, output action, output group_index,
		output channel_index, output fader_level, input ready);
	modport sink (input valid, input action, input group_index,
		input channel_index, input fader_level, output ready);
endinterface

// ----- rtl/core/vgg_out_if.sv -----
// response channel: one result per transfer
`timescale 1ns / 1ps

interface vgg_out_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [vgg_pkg::NEWG_W-1:0]    new_group;
	logic [vgg_pkg::GAIN_W-1:0]    channel_gain;

	modport source (output valid, output status, output new_group,
		output channel_gain, input ready);
	modport sink (input valid, input status, input new_group,
		input channel_gain, output ready);
endinterface

// ----- rtl/core/vca_group_gain_core.sv -----
// top level of the vca group gain core: sequencer plus datapath
`timescale 1ns / 1ps

// channel  | dir | payload                                        | transfer
// ---------+-----+------------------------------------------------+---------------------
// req      | in  | action, group_index, channel_index, fader_level | req.valid & req.ready
// rsp      | out | status, new_group, channel_gain                 | rsp.valid & rsp.ready
//
// one action at a time; req reopens once the result moves into the output register
// create, assign, unassign and set fader: decode, then straight to the hand-off
// query: decode, then the one-group-per-cycle fader walk over the created groups
// and then clamp and a table read before the hand-off
// a stalled rsp holds the next result in the pending register until the output register frees
// arst_n clears the group count and handshake; a group is zeroed when created

module vca_group_gain_core #(
	parameter int GROUP_COUNT   = vgg_pkg::GROUP_COUNT_DEF,
	parameter int CHANNEL_COUNT = vgg_pkg::CHANNEL_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vgg_in_if.sink    req,
	vgg_out_if.source rsp
);

	// command and status between sequencer and datapath
	vgg_pkg::vgg_cmd_t  cmd;
	vgg_pkg::vgg_stat_t st;

	// sequencer: accept, decode, walk, clamp, table read, hand off
	vgg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// datapath: group stores, sum walk, gain table, output register
	vgg_dpath #(
		.GROUP_COUNT   (GROUP_COUNT),
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

endmodule

// ----- rtl/core/vgg_ctrl.sv -----
// sequencer for the vca group gain core
`timescale 1ns / 1ps
`include "vca_group_gain_core_assert.svh"

module vgg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  vgg_pkg::vgg_stat_t st,
	output vgg_pkg::vgg_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_CLAMP,
		ST_ROM,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd       = '0;
		cmd.ready = ready_q;
		cmd.load  = ready_q && st.in_valid;
		cmd.start = (state_q == ST_DECODE);
		cmd.exec  = (state_q == ST_DECODE) && !st.is_query;
		cmd.walk  = (state_q == ST_WALK);
		cmd.clamp = (state_q == ST_CLAMP);
		cmd.rom   = (state_q == ST_ROM);
		cmd.push  = (state_q == ST_DONE) && !st.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ready_q && st.in_valid) begin
						state_q <= ST_DECODE;
						ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					if (!st.is_query)
						state_q <= ST_DONE;
					else if (st.none_in_use)
						state_q <= ST_CLAMP;
					else
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (st.walk_last)
						state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					state_q <= ST_ROM;
				end
				ST_ROM: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!st.out_busy) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	`VGG_ASSERT_NOW(a_ready_only_idle, ready_q, state_q == ST_IDLE)
	`VGG_ASSERT_NEXT(a_transfer_decodes, cmd.load, state_q == ST_DECODE)
	`VGG_ASSERT_NOW(a_walk_has_groups, state_q == ST_WALK, !st.none_in_use)

endmodule

// ----- rtl/core/vgg_dpath.sv -----
// group stores, fader sum walk, gain table and result register
`timescale 1ns / 1ps
`include "vca_group_gain_core_assert.svh"

module vgg_dpath #(
	parameter int GROUP_COUNT   = vgg_pkg::GROUP_COUNT_DEF,
	parameter int CHANNEL_COUNT = vgg_pkg::CHANNEL_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	vgg_in_if.sink             req,
	vgg_out_if.source          rsp,
	input  vgg_pkg::vgg_cmd_t  cmd,
	output vgg_pkg::vgg_stat_t st
);

	localparam int GI_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int CNT_W    = $clog2(GROUP_COUNT + 1);
	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int CMP_W    = (CNT_W > vgg_pkg::GROUP_W) ? CNT_W : vgg_pkg::GROUP_W;
	localparam int CH_CMP_W = vgg_pkg::CHANNEL_W + 1;
	localparam int FADER_W  = vgg_pkg::FADER_W;
	localparam int SUM_W    = FADER_W + $clog2(GROUP_COUNT) + 1;
	localparam int ROM_AW   = vgg_pkg::ROM_AW;

	localparam logic [CNT_W-1:0]        CntMax = CNT_W'(GROUP_COUNT);
	localparam logic signed [SUM_W-1:0] SumLo  = SUM_W'(vgg_pkg::SUM_MIN);
	localparam logic signed [SUM_W-1:0] SumHi  = SUM_W'(vgg_pkg::SUM_MAX);
	localparam logic [ROM_AW-1:0]       RomTop = ROM_AW'(vgg_pkg::ROM_DEPTH - 1);
	localparam vgg_pkg::gain_rom_t      GainRom = vgg_pkg::build_gain_rom();

	// captured item
	logic [vgg_pkg::ACTION_W-1:0]  action_q;
	logic [vgg_pkg::GROUP_W-1:0]   grp_q;
	logic [vgg_pkg::CHANNEL_W-1:0] ch_q;
	logic signed [FADER_W-1:0]     level_q;

	// group stores
	logic [CNT_W-1:0]          in_use_q;
	logic signed [FADER_W-1:0] fader_q [GROUP_COUNT];
	logic [CHANNEL_COUNT-1:0]  memb_q  [GROUP_COUNT];

	// query walk
	logic [GI_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ROM_AW-1:0]       addr_q;

	// pending result and output register
	logic                          res_status_q;
	logic [vgg_pkg::NEWG_W-1:0]    res_newg_q;
	logic [vgg_pkg::GAIN_W-1:0]    res_gain_q;
	logic                          out_valid_q;
	logic                          out_status_q;
	logic [vgg_pkg::NEWG_W-1:0]    out_newg_q;
	logic [vgg_pkg::GAIN_W-1:0]    out_gain_q;

	logic                    grp_ok;
	logic                    ch_ok;
	logic                    groups_full;
	logic [GI_W-1:0]         grp_idx;
	logic [GI_W-1:0]         new_idx;
	logic [CH_IDX_W-1:0]     ch_idx;
	logic signed [SUM_W-1:0] walk_term;
	logic [ROM_AW-1:0]       clamp_addr;

	assign grp_ok      = CMP_W'(grp_q) < CMP_W'(in_use_q);
	assign ch_ok       = CH_CMP_W'(ch_q) < CH_CMP_W'(CHANNEL_COUNT);
	assign groups_full = (in_use_q == CntMax);
	assign grp_idx     = GI_W'(grp_q);
	assign new_idx     = GI_W'(in_use_q);
	assign ch_idx      = CH_IDX_W'(ch_q);

	// member faders add in, others add zero
	assign walk_term = memb_q[cnt_q][ch_idx]
		? {{(SUM_W - FADER_W){fader_q[cnt_q][FADER_W-1]}}, fader_q[cnt_q]}
		: '0;

	always_comb begin
		if (sum_q < SumLo)
			clamp_addr = '0;
		else if (sum_q > SumHi)
			clamp_addr = RomTop;
		else
			clamp_addr = ROM_AW'(sum_q - SumLo);
	end

	assign st.in_valid    = req.valid;
	assign st.is_query    = (action_q == vgg_pkg::ACT_QUERY) && ch_ok;
	assign st.none_in_use = (in_use_q == '0);
	assign st.walk_last   = (CNT_W'(cnt_q) == in_use_q - CNT_W'(1));
	assign st.out_busy    = out_valid_q && !rsp.ready;

	assign req.ready        = cmd.ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.new_group    = out_newg_q;
	assign rsp.channel_gain = out_gain_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			grp_q    <= req.group_index;
			ch_q     <= req.channel_index;
			level_q  <= req.fader_level;
		end
	end

	// created group count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cmd.exec && action_q == vgg_pkg::ACT_CREATE && !groups_full) begin
			in_use_q <= in_use_q + CNT_W'(1);
		end
	end

	// group stores; a new group is cleared when it is created
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			unique case (action_q)
				vgg_pkg::ACT_CREATE: begin
					if (!groups_full) begin
						fader_q[new_idx] <= '0;
						memb_q[new_idx]  <= '0;
					end
				end
				vgg_pkg::ACT_ASSIGN: begin
					if (grp_ok && ch_ok)
						memb_q[grp_idx][ch_idx] <= 1'b1;
				end
				vgg_pkg::ACT_UNASSIGN: begin
					if (grp_ok && ch_ok)
						memb_q[grp_idx][ch_idx] <= 1'b0;
				end
				vgg_pkg::ACT_SET_FADER: begin
					if (grp_ok)
						fader_q[grp_idx] <= level_q;
				end
				default: begin
				end
			endcase
		end
	end

	// query walk, one group a cycle, then clamp to a table address
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.walk) begin
			cnt_q <= cnt_q + GI_W'(1);
			sum_q <= sum_q + walk_term;
		end
		if (cmd.clamp)
			addr_q <= clamp_addr;
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= vgg_pkg::STAT_DONE;
			res_newg_q   <= '0;
			res_gain_q   <= vgg_pkg::UNITY_GAIN;
			case (action_q)
				vgg_pkg::ACT_CREATE: begin
					if (groups_full)
						res_status_q <= vgg_pkg::STAT_REJECTED;
					else
						res_newg_q <= vgg_pkg::NEWG_W'(in_use_q);
				end
				vgg_pkg::ACT_ASSIGN, vgg_pkg::ACT_UNASSIGN, vgg_pkg::ACT_SET_FADER: begin
					if (!grp_ok)
						res_status_q <= vgg_pkg::STAT_REJECTED;
				end
				default: begin
				end
			endcase
		end else if (cmd.rom) begin
			res_status_q <= vgg_pkg::STAT_DONE;
			res_newg_q   <= '0;
			res_gain_q   <= GainRom[addr_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_newg_q   <= res_newg_q;
			out_gain_q   <= res_gain_q;
		end
	end

	`VGG_ASSERT_NOW(a_count_bound, 1'b1, in_use_q <= CntMax)
	`VGG_ASSERT_NOW(a_walk_in_range, cmd.walk, CNT_W'(cnt_q) < in_use_q)
	`VGG_ASSERT_NOW(a_push_into_free, cmd.push, !(out_valid_q && !rsp.ready))

endmodule

// ----- bench/vca_group_gain_core_tb.sv -----
// self-checking testbench for vca_group_gain_core: directed and random actions against a local gain predictor
`timescale 1ns / 1ps

module vca_group_gain_core_tb;

	import vgg_pkg::*;

	// spare action codes that the block answers with defaults
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

	localparam int GROUP_LIMIT   = GROUP_COUNT_DEF;
	localparam int CHANNEL_LIMIT = CHANNEL_COUNT_DEF;
	localparam int MAX_WAIT      = 18;
	localparam int QUIET_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [GROUP_W-1:0]        group_index;
		logic [CHANNEL_W-1:0]      channel_index;
		logic signed [FADER_W-1:0] fader_level;
	} vca_action_t;

	typedef struct packed {
		logic               status;
		logic [NEWG_W-1:0]  new_group;
		logic [GAIN_W-1:0]  channel_gain;
	} vca_answer_t;

	logic clk;
	logic arst_n;

	vgg_in_if  req_ch ();
	vgg_out_if rsp_ch ();

	vca_group_gain_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// local copy of the group table, updated at every request transfer
	int                        grp_count;
	logic signed [FADER_W-1:0] fader_mem  [GROUP_LIMIT];
	logic [CHANNEL_LIMIT-1:0]  member_mem [GROUP_LIMIT];

	// answers the block still owes, oldest first
	vca_answer_t pending_answers [$];

	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// atanh(1/p) in q4.60, series truncated after 40 terms
	function automatic logic [63:0] atanh_recip(input logic [63:0] p);
		logic [63:0] pw;
		logic [63:0] acc;
		pw = Q_ONE / p;
		acc = '0;
		for (int k = 0; k < 40; k++) begin
			acc = acc + pw / 64'(2 * k + 1);
			pw = pw / (p * p);
		end
		return acc;
	endfunction

	// clamped fader sum in 1/16 dB to linear gain in q4.20
	function automatic logic [GAIN_W-1:0] fader_sum_to_gain(input int sum16);
		logic [63:0]  ln10;
		logic [63:0]  y;
		logic [63:0]  term;
		logic [63:0]  v;
		logic [63:0]  x;
		logic [127:0] prod;
		int           off;
		int           decade;
		int           frac;
		ln10 = 64'd6 * atanh_recip(64'd3) + 64'd2 * atanh_recip(64'd9);
		// split into whole decades and a remainder of 0..319 sixteenths
		off = sum16 + 2560;
		decade = off / 320 - 8;
		frac = off % 320;
		y = (ln10 / 64'd320) * 64'(frac) + ((ln10 % 64'd320) * 64'(frac)) / 64'd320;
		// e^y by its taylor series, each product truncated back to q4.60
		term = Q_ONE;
		v = Q_ONE;
		for (int n = 1; n < 40; n++) begin
			prod = {64'd0, term} * {64'd0, y};
			term = prod[123:60] / 64'(n);
			v = v + term;
		end
		x = v;
		if (decade > 0) begin
			for (int j = 0; j < decade; j++)
				x = x * 64'd10;
		end else begin
			for (int j = 0; j < -decade; j++)
				x = x / 64'd10;
		end
		// q4.60 to q4.20, rounding half up
		return GAIN_W'((x + (64'd1 << 39)) >> 40);
	endfunction

	// applies one action to the local group table and returns the answer it earns
	function automatic vca_answer_t apply_action(input vca_action_t a);
		vca_answer_t ans;
		int          sum16;
		ans.status = STAT_DONE;
		ans.new_group = '0;
		ans.channel_gain = UNITY_GAIN;
		sum16 = 0;
		case (a.action)
			ACT_CREATE: begin
				if (grp_count >= GROUP_LIMIT) begin
					ans.status = STAT_REJECTED;
				end else begin
					fader_mem[grp_count] = '0;
					member_mem[grp_count] = '0;
					ans.new_group = NEWG_W'(grp_count);
					grp_count++;
				end
			end
			ACT_ASSIGN, ACT_UNASSIGN, ACT_SET_FADER: begin
				if (int'(a.group_index) >= grp_count) begin
					ans.status = STAT_REJECTED;
				end else if (a.action == ACT_SET_FADER) begin
					fader_mem[a.group_index] = a.fader_level;
				end else if (a.action == ACT_ASSIGN) begin
					member_mem[a.group_index][a.channel_index] = 1'b1;
				end else begin
					member_mem[a.group_index][a.channel_index] = 1'b0;
				end
			end
			ACT_QUERY: begin
				for (int g = 0; g < grp_count; g++) begin
					if (member_mem[g][a.channel_index])
						sum16 += int'(fader_mem[g]);
				end
				if (sum16 < SUM_MIN)
					sum16 = SUM_MIN;
				if (sum16 > SUM_MAX)
					sum16 = SUM_MAX;
				ans.channel_gain = fader_sum_to_gain(sum16);
			end
			default: ;
		endcase
		return ans;
	endfunction

	// one request transfer; valid stays high when the next item follows with no gap,
	// so it is never lowered and raised in the same time step
	task automatic send_action(input logic [ACTION_W-1:0] act, input logic [GROUP_W-1:0] grp,
			input logic [CHANNEL_W-1:0] ch, input logic signed [FADER_W-1:0] level);
		vca_action_t item;
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item = '{act, grp, ch, level};
		req_ch.valid         <= 1'b1;
		req_ch.action        <= act;
		req_ch.group_index   <= grp;
		req_ch.channel_index <= ch;
		req_ch.fader_level   <= level;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_answers.push_back(apply_action(item));
	endtask

	// response side: random stalls per result, every transfer checked against the oldest answer
	initial begin : rsp_side
		int unsigned hold;
		vca_answer_t got;
		vca_answer_t want;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.new_group = rsp_ch.new_group;
				got.channel_gain = rsp_ch.channel_gain;
				if (pending_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: status=%0d new_group=%0d gain=%0d",
							got.status, got.new_group, got.channel_gain);
				end else begin
					want = pending_answers.pop_front();
					if (got.status !== want.status || got.new_group !== want.new_group
							|| got.channel_gain !== want.channel_gain) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: exp status=%0d new_group=%0d gain=%0d, got status=%0d new_group=%0d gain=%0d",
								want.status, want.new_group, want.channel_gain,
								got.status, got.new_group, got.channel_gain);
					end
				end
				hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
				rsp_ch.ready <= (hold == 0);
			end else if (!rsp_ch.ready) begin
				if (hold == 0)
					rsp_ch.ready <= 1'b1;
				else
					hold--;
			end
		end
	end

	// watchdog: a stuck handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// before any group exists: default answers and rejects on every group action
	task automatic test_empty_table();
		send_action(ACT_QUERY, 4'd0, 6'd0, 12'sd0);
		send_action(ACT_QUERY, 4'd15, 6'd63, -12'sd1);
		send_action(ACT_ASSIGN, 4'd0, 6'd1, 12'sd0);
		send_action(ACT_UNASSIGN, 4'd15, 6'd63, 12'sd0);
		send_action(ACT_SET_FADER, 4'd3, 6'd0, 12'sd384);
		send_action(ACT_SPARE_A, 4'd15, 6'd63, -12'sd2048);
		send_action(ACT_SPARE_B, 4'd0, 6'd0, 12'sd2047);
		send_action(ACT_SPARE_C, 4'd10, 6'd42, -12'sd1);
	endtask

	// two groups: fader extremes, out-of-range faders, both clamp ends, unassign
	task automatic test_first_groups();
		send_action(ACT_CREATE, 4'd0, 6'd0, 12'sd0);
		send_action(ACT_CREATE, 4'd15, 6'd63, -12'sd1);
		send_action(ACT_SET_FADER, 4'd0, 6'd0, 12'sd384);
		send_action(ACT_SET_FADER, 4'd1, 6'd0, -12'sd2048);
		send_action(ACT_ASSIGN, 4'd0, 6'd63, 12'sd0);
		send_action(ACT_ASSIGN, 4'd1, 6'd63, 12'sd0);
		send_action(ACT_ASSIGN, 4'd0, 6'd0, 12'sd0);
		// top of the clamp range, then a sum inside the range
		send_action(ACT_QUERY, 4'd0, 6'd0, 12'sd0);
		send_action(ACT_QUERY, 4'd0, 6'd63, 12'sd0);
		// a stored value above the clamp range drives the sum past the upper clamp
		send_action(ACT_SET_FADER, 4'd1, 6'd0, 12'sd2047);
		send_action(ACT_QUERY, 4'd0, 6'd63, 12'sd0);
		// both groups at the bottom push the sum below the lower clamp
		send_action(ACT_SET_FADER, 4'd0, 6'd0, -12'sd2048);
		send_action(ACT_SET_FADER, 4'd1, 6'd0, -12'sd2048);
		send_action(ACT_QUERY, 4'd0, 6'd63, 12'sd0);
		send_action(ACT_UNASSIGN, 4'd0, 6'd63, 12'sd0);
		send_action(ACT_UNASSIGN, 4'd1, 6'd5, 12'sd0);
		send_action(ACT_QUERY, 4'd0, 6'd63, 12'sd0);
	endtask

	// fill the table, then creates beyond it are refused and the last group works
	task automatic test_groups_full();
		while (grp_count < GROUP_LIMIT)
			send_action(ACT_CREATE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
				12'($urandom_range(0, 4095)));
		send_action(ACT_CREATE, 4'd0, 6'd0, 12'sd0);
		send_action(ACT_CREATE, 4'd15, 6'd63, -12'sd1);
		send_action(ACT_SET_FADER, 4'd15, 6'd0, -12'sd160);
		send_action(ACT_ASSIGN, 4'd15, 6'd5, 12'sd0);
		send_action(ACT_QUERY, 4'd0, 6'd5, 12'sd0);
	endtask

	// mostly well-formed traffic on created groups and a few busy channels
	task automatic run_random_traffic(input int unsigned item_total);
		int unsigned      pick;
		logic [ACTION_W-1:0] act;
		logic [GROUP_W-1:0]  grp;
		logic [CHANNEL_W-1:0] ch;
		logic signed [FADER_W-1:0] level;
		for (int unsigned i = 0; i < item_total; i++) begin
			// stretches with and without idling on both sides
			if (i % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				act = ACT_CREATE;
			else if (pick < 33)
				act = ACT_ASSIGN;
			else if (pick < 45)
				act = ACT_UNASSIGN;
			else if (pick < 65)
				act = ACT_SET_FADER;
			else if (pick < 96)
				act = ACT_QUERY;
			else begin
				case ($urandom_range(0, 2))
					0: act = ACT_SPARE_A;
					1: act = ACT_SPARE_B;
					default: act = ACT_SPARE_C;
				endcase
			end
			if (grp_count != 0 && $urandom_range(0, 9) < 8)
				grp = 4'($urandom_range(0, grp_count - 1));
			else
				grp = 4'($urandom_range(0, 15));
			// a small pool of channels keeps memberships overlapping
			if ($urandom_range(0, 2) == 0)
				ch = 6'($urandom_range(0, 63));
			else
				ch = 6'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				0: level = 12'($urandom_range(0, 4095));
				1: begin
					case ($urandom_range(0, 3))
						0: level = -12'sd2048;
						1: level = 12'sd384;
						2: level = 12'sd2047;
						default: level = -12'sd1;
					endcase
				end
				// small faders keep many sums inside the clamp range
				default: level = 12'(int'($urandom_range(0, 600)) - 400);
			endcase
			send_action(act, grp, ch, level);
		end
	endtask

	// drop valid, collect every owed answer, let the block settle, report
	task automatic finish_run();
		req_ch.valid <= 1'b0;
		idle_on = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	endtask

	initial begin : stimulus
		grp_count = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		for (int g = 0; g < GROUP_LIMIT; g++) begin
			fader_mem[g] = '0;
			member_mem[g] = '0;
		end
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.action        <= ACT_CREATE;
		req_ch.group_index   <= '0;
		req_ch.channel_index <= '0;
		req_ch.fader_level   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_first_groups();
		run_random_traffic(200);
		test_groups_full();
		run_random_traffic(230);
		finish_run();
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/vgg_pkg.sv
rtl/core/vgg_in_if.sv
rtl/core/vgg_out_if.sv
rtl/core/vgg_ctrl.sv
rtl/core/vgg_dpath.sv
rtl/core/vca_group_gain_core.sv
bench/vca_group_gain_core_tb.sv
